[sv/modexp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_pkg
// Shared widths, register indexes and controller/datapath command types for
// the modular exponentiation block.
// ----------------------------------------------------------------------------
package modexp_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned CntW  = 6;   // counts the 64 bits of an operand
  localparam int unsigned CfgAw = 2;

  localparam logic [CfgAw-1:0] RegPubExp  = 2'd0;
  localparam logic [CfgAw-1:0] RegPrivExp = 2'd1;
  localparam logic [CfgAw-1:0] RegModulus = 2'd2;

  localparam logic ActEncrypt = 1'b0;
  localparam logic ActDecrypt = 1'b1;

  typedef struct packed {
    logic load;       // latch a new transaction
    logic set_one;    // zero exponent: accumulator becomes one
    logic red_step;   // one bit of the base reduction
    logic red_done;   // store reduced base, initialize accumulator
    logic mul_start;  // load multiplier operand and clear partial product
    logic mul_sel;    // 0 square, 1 multiply by base
    logic mul_step;   // one bit of the modular multiply
    logic commit;     // accumulator takes the product
    logic exp_shift;  // move to the next exponent bit
    logic finish;     // write the result register
  } cmd_t;

  typedef struct packed {
    logic expo_zero;
    logic expo_msb;
  } sts_t;

endpackage : modexp_pkg
`default_nettype wire

[sv/modular_exponentiation.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation
// Raises a message byte or a ciphertext to a key exponent modulo n.
// ----------------------------------------------------------------------------
//  Channel | Handshake               | Payload
//  --------+-------------------------+------------------------------
//  in      | in_valid_i / in_stall_o | action_i, value_i
//  out     | out_valid_o/out_stall_i | result_o
//  cfg     | cfg_we_i                | cfg_addr_i, cfg_wdata_i
//
// A transaction runs a base reduction, then for every exponent bit a square
// plus a multiply when the bit is set; each pass goes through the
// one-bit-per-cycle modular double-and-add unit.
// A zero exponent skips reduction and products. No clearing pass after reset.
// The next transaction is taken while a result still waits on a stalled out.
// ----------------------------------------------------------------------------
module modular_exponentiation (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [modexp_pkg::CfgAw-1:0]  cfg_addr_i,
  input  wire logic [modexp_pkg::DataW-1:0]  cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          action_i,
  input  wire logic [modexp_pkg::DataW-1:0]  value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [modexp_pkg::DataW-1:0]       result_o
);
  import modexp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  modexp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  modexp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .action_i    (action_i),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .result_o    (result_o)
  );

endmodule : modular_exponentiation
`default_nettype wire

[sv/modexp_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_ctrl
// Sequencer for square-and-multiply: base reduction, then one square and an
// optional multiply per exponent bit, each a 64-step bit-serial product.
// ----------------------------------------------------------------------------
module modexp_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire modexp_pkg::sts_t  sts_i,
  output modexp_pkg::cmd_t       cmd_o
);
  import modexp_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StLoad, StRed, StRedDone, StStart, StStep, StCommit, StDone
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] step_q, step_d;
  logic [CntW-1:0] ebit_q, ebit_d;
  logic            sel_q, sel_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    ebit_d      = ebit_q;
    sel_d       = sel_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.mul_sel = sel_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StLoad;
        end
      end
      StLoad: begin
        step_d = '0;
        ebit_d = '0;
        sel_d  = 1'b0;
        if (sts_i.expo_zero) begin
          cmd_o.set_one = 1'b1;
          state_d       = StDone;
        end else begin
          state_d = StRed;
        end
      end
      StRed: begin
        cmd_o.red_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (&step_q) state_d = StRedDone;
      end
      StRedDone: begin
        cmd_o.red_done = 1'b1;
        state_d        = StStart;
      end
      StStart: begin
        cmd_o.mul_start = 1'b1;
        step_d          = '0;
        state_d         = StStep;
      end
      StStep: begin
        cmd_o.mul_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (&step_q) state_d = StCommit;
      end
      StCommit: begin
        cmd_o.commit = 1'b1;
        if (!sel_q && sts_i.expo_msb) begin
          sel_d   = 1'b1;
          state_d = StStart;
        end else begin
          cmd_o.exp_shift = 1'b1;
          sel_d           = 1'b0;
          ebit_d          = ebit_q + 1'b1;
          state_d         = (&ebit_q) ? StDone : StStart;
        end
      end
      StDone: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      ebit_q      <= '0;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      ebit_q      <= ebit_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule : modexp_ctrl
`default_nettype wire

[sv/modexp_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// modexp_dp
// Datapath: key registers, exponent shifter, accumulator and a shared
// bit-serial modular double-and-add step used for reduction and products.
// ----------------------------------------------------------------------------
module modexp_dp (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [modexp_pkg::CfgAw-1:0]       cfg_addr_i,
  input  wire logic [modexp_pkg::DataW-1:0]       cfg_wdata_i,
  input  wire logic                               action_i,
  input  wire logic [modexp_pkg::DataW-1:0]       value_i,
  input  wire modexp_pkg::cmd_t                   cmd_i,
  output modexp_pkg::sts_t                        sts_o,
  output logic [modexp_pkg::DataW-1:0]            result_o
);
  import modexp_pkg::*;

  logic [DataW-1:0] pub_q, priv_q, mod_q;
  logic [DataW-1:0] n_q, base_q, expo_q, acc_q, macc_q, mb_q, result_q;
  logic             act_q;

  // Step: x = 2*macc + addend, then reduced. Operands stay below n, so x is
  // below 3n and at most two subtractions of n are needed.
  logic [DataW-1:0] addend, step_res;
  logic [DataW+1:0] x, n1, n2, d1, d2;
  logic             n_zero;

  assign n_zero = (n_q == '0);
  assign n1     = {2'b00, n_q};
  assign n2     = {1'b0, n_q, 1'b0};
  assign x      = {1'b0, macc_q, 1'b0} + {2'b00, addend};
  assign d1     = x - n1;
  assign d2     = x - n2;

  always_comb begin
    if (cmd_i.red_step) addend = {{(DataW-1){1'b0}}, mb_q[DataW-1]};
    else                addend = mb_q[DataW-1] ? acc_q : '0;
    if (n_zero)       step_res = x[DataW-1:0];
    else if (x >= n2) step_res = d2[DataW-1:0];
    else if (x >= n1) step_res = d1[DataW-1:0];
    else              step_res = x[DataW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pub_q  <= '0;
      priv_q <= '0;
      mod_q  <= {{(DataW-1){1'b0}}, 1'b1};
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegPubExp:  pub_q  <= cfg_wdata_i;
        RegPrivExp: priv_q <= cfg_wdata_i;
        RegModulus: mod_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q    <= mod_q;
      act_q  <= action_i;
      expo_q <= (action_i == ActDecrypt) ? priv_q : pub_q;
      mb_q   <= (action_i == ActDecrypt) ? value_i
                                         : {{(DataW-8){1'b0}}, value_i[7:0]};
      macc_q <= '0;
    end
    if (cmd_i.set_one) acc_q <= {{(DataW-1){1'b0}}, 1'b1};
    if (cmd_i.red_step || cmd_i.mul_step) begin
      macc_q <= step_res;
      mb_q   <= {mb_q[DataW-2:0], 1'b0};
    end
    if (cmd_i.red_done) begin
      base_q <= macc_q;
      // With a modulus of one every residue is zero.
      acc_q  <= (n_q == {{(DataW-1){1'b0}}, 1'b1}) ? '0 : {{(DataW-1){1'b0}}, 1'b1};
    end
    if (cmd_i.mul_start) begin
      macc_q <= '0;
      mb_q   <= cmd_i.mul_sel ? base_q : acc_q;
    end
    if (cmd_i.commit)    acc_q  <= macc_q;
    if (cmd_i.exp_shift) expo_q <= {expo_q[DataW-2:0], 1'b0};
    if (cmd_i.finish) begin
      result_q <= (act_q == ActDecrypt) ? {{(DataW-8){1'b0}}, acc_q[7:0]} : acc_q;
    end
  end

  assign sts_o.expo_zero = (expo_q == '0);
  assign sts_o.expo_msb  = expo_q[DataW-1];
  assign result_o        = result_q;

endmodule : modexp_dp
`default_nettype wire
